FILE: hw/rtl/vptw_pkg.sv
// ----------------------------------------------------------------------------
// vptw_pkg
// shared types and constants of the vertex projection unit
// ----------------------------------------------------------------------------
package vptw_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgVpX = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgVpY = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgVpW = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgVpH = 2'd3;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdProject = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StMac,
    StRowEnd,
    StDivStart,
    StDiv,
    StDivEnd,
    StVpMul,
    StVpEnd,
    StOut
  } vptw_state_e;

  // controller to datapath
  typedef struct packed {
    logic       start;      // capture vertex, clear flag
    logic       mac;        // one multiply-accumulate
    logic       row_end;    // saturate accumulator into vector slot
    logic [3:0] mac_sel;    // pass (bit 3), row (2:1) ... see datapath
    logic       div_start;
    logic       div_step;
    logic       div_end;
    logic [1:0] comp;       // component for divide / viewport
    logic       vp_mul;
    logic       vp_end;
    logic       load_out;
  } vptw_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic w_zero;
  } vptw_sts_t;

endpackage

FILE: hw/rtl/vptw_stream_if.sv
// ----------------------------------------------------------------------------
// vptw_stream_if
// valid / ready channel carrying one payload item
// ----------------------------------------------------------------------------
interface vptw_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/vertex_project_to_window_unit.sv
// ----------------------------------------------------------------------------
// vertex_project_to_window_unit
// fixed-point vertex projection from object space to window coordinates
// ----------------------------------------------------------------------------
// channels: in_if carries either a matrix element load (cmd 0) or a vertex to
// project (cmd 1); out_if returns one item per projected vertex, none for loads
// the user must set the viewport through the cfg write port while the unit is
// idle; the block itself does not enforce it; loads are taken and the next
// item may follow at once; a vertex walks two 4x4 matrix products on one
// shared 32x32 multiplier, four multiply-accumulate steps plus one row close
// for each of eight rows, then three restoring divides by clip w of
// FracBits+33 steps, each with a start and an end step, then two viewport
// multiplies, each with a multiply step and an offset-add step; the serial
// divider takes the largest share of the time per vertex
// when clip w is zero the divides are skipped and ok is returned low
// the finished item sits in an output register, so a stalled receiver only
// holds back the following vertex at its last step
// reset restores identity matrices (tracked by per-element written bits) and
// the default 640 by 480 viewport at origin zero
// ----------------------------------------------------------------------------
module vertex_project_to_window_unit
  import vptw_pkg::*;
#(
  parameter int unsigned FracBits = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  vptw_stream_if.sink         in_if,
  vptw_stream_if.source       out_if,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  vptw_cmd_t cmd;
  vptw_sts_t sts;
  logic load_en;

  vptw_ctrl #(
    .DivSteps(FracBits + 32 + 1)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_cmd_i   (in_if.data.cmd),
    .in_ready_o (in_if.ready),
    .load_en_o  (load_en),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  vptw_dpath #(
    .FracBits(FracBits)
  ) u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_en_i (load_en),
    .load_sel_i(in_if.data.matrix_select),
    .load_idx_i(in_if.data.element_index),
    .load_val_i(in_if.data.element_value),
    .obj_x_i   (in_if.data.object_x),
    .obj_y_i   (in_if.data.object_y),
    .obj_z_i   (in_if.data.object_z),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .ok_o      (out_if.data.ok),
    .sat_o     (out_if.data.saturated),
    .wx_o      (out_if.data.window_x),
    .wy_o      (out_if.data.window_y),
    .wz_o      (out_if.data.window_z)
  );

endmodule

FILE: hw/rtl/vptw_ctrl.sv
// ----------------------------------------------------------------------------
// vptw_ctrl
// sequencer for matrix products, divides and viewport mapping
// ----------------------------------------------------------------------------
module vptw_ctrl
  import vptw_pkg::*;
#(
  parameter int unsigned DivSteps = 48
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_cmd_i,
  output logic      in_ready_o,
  output logic      load_en_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output vptw_cmd_t cmd_o,
  input  vptw_sts_t sts_i
);

  localparam int unsigned DivCntW = $clog2(DivSteps + 1);

  vptw_state_e state_q, state_d;
  logic [4:0] mac_q, mac_d;   // pass, row, col
  logic [1:0] comp_q, comp_d;
  logic [DivCntW-1:0] div_q, div_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      mac_q <= '0;
      comp_q <= '0;
      div_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mac_q <= mac_d;
      comp_q <= comp_d;
      div_q <= div_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    mac_d = mac_q;
    comp_d = comp_q;
    div_d = div_q;
    out_valid_d = out_valid_q;
    cmd_o = '0;
    cmd_o.mac_sel = mac_q[4:1];
    cmd_o.comp = comp_q;
    in_ready_o = 1'b0;
    load_en_o = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_cmd_i == CmdLoad) begin
            load_en_o = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            mac_d = '0;
            state_d = StMac;
          end
        end
      end
      StMac: begin
        cmd_o.mac = 1'b1;
        cmd_o.mac_sel = {mac_q[4], mac_q[3:2], 1'b0};
        mac_d = mac_q + 5'd1;
        if (mac_q[1:0] == 2'd3) begin
          state_d = StRowEnd;
        end
      end
      StRowEnd: begin
        cmd_o.row_end = 1'b1;
        cmd_o.mac_sel = {mac_q[4] ^ (mac_q[3:0] == 4'd0), mac_q[3:2] - 2'd1, 1'b0};
        if (mac_q == 5'd0) begin
          comp_d = '0;
          state_d = StDivStart;
        end else begin
          state_d = StMac;
        end
      end
      StDivStart: begin
        if (sts_i.w_zero) begin
          state_d = StOut;
        end else begin
          cmd_o.div_start = 1'b1;
          div_d = '0;
          state_d = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        div_d = div_q + 1'b1;
        if (div_q == DivCntW'(DivSteps - 1)) begin
          state_d = StDivEnd;
        end
      end
      StDivEnd: begin
        cmd_o.div_end = 1'b1;
        if (comp_q == 2'd2) begin
          comp_d = '0;
          state_d = StVpMul;
        end else begin
          comp_d = comp_q + 2'd1;
          state_d = StDivStart;
        end
      end
      StVpMul: begin
        cmd_o.vp_mul = 1'b1;
        state_d = StVpEnd;
      end
      StVpEnd: begin
        cmd_o.vp_end = 1'b1;
        if (comp_q == 2'd1) begin
          state_d = StOut;
        end else begin
          comp_d = comp_q + 2'd1;
          state_d = StVpMul;
        end
      end
      StOut: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hw/rtl/vptw_dpath.sv
// ----------------------------------------------------------------------------
// vptw_dpath
// matrix stores, shared multiplier, restoring divider and viewport scaling
// ----------------------------------------------------------------------------
module vptw_dpath
  import vptw_pkg::*;
#(
  parameter int unsigned FracBits = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_en_i,
  input  logic               load_sel_i,
  input  logic [3:0]         load_idx_i,
  input  logic signed [31:0] load_val_i,
  input  logic signed [31:0] obj_x_i,
  input  logic signed [31:0] obj_y_i,
  input  logic signed [31:0] obj_z_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  vptw_cmd_t          cmd_i,
  output vptw_sts_t          sts_o,
  output logic               ok_o,
  output logic               sat_o,
  output logic signed [31:0] wx_o,
  output logic signed [31:0] wy_o,
  output logic signed [31:0] wz_o
);

  localparam int unsigned QW = 32 + FracBits + 1;       // dividend magnitude
  localparam logic signed [31:0] One = 32'sd1 <<< FracBits;

  logic signed [31:0] mv_q [16];
  logic signed [31:0] pj_q [16];
  logic [15:0] mv_wr_q, pj_wr_q;  // entry written since reset

  logic signed [15:0] vpx_q, vpy_q;
  logic [14:0] vpw_q, vph_q;

  logic signed [31:0] vin_q [4];  // vector being multiplied
  logic signed [31:0] vout_q [4]; // result of the pass
  logic signed [65:0] acc_q;
  logic [1:0] col_q;
  logic sat_q;

  logic [QW-1:0] rem_q, quo_q;
  logic [32:0] dvs_q;
  logic neg_q;
  logic signed [31:0] m_q [3];
  logic signed [48:0] prod_q;
  logic signed [31:0] win_q [2];

  logic ok_q, osat_q;
  logic signed [31:0] owx_q, owy_q, owz_q;

  function automatic logic signed [31:0] ident(input logic [3:0] i);
    return (i == 4'd0 || i == 4'd5 || i == 4'd10 || i == 4'd15) ? One : 32'sd0;
  endfunction

  // matrix element for current mac
  logic [3:0] eidx;
  logic signed [31:0] elem;
  logic signed [63:0] mprod;
  logic signed [63:0] pshift;
  assign eidx = {col_q, cmd_i.mac_sel[2:1]};
  always_comb begin
    if (cmd_i.mac_sel[3]) begin
      elem = pj_wr_q[eidx] ? pj_q[eidx] : ident(eidx);
    end else begin
      elem = mv_wr_q[eidx] ? mv_q[eidx] : ident(eidx);
    end
  end
  assign mprod = elem * vin_q[col_q];
  assign pshift = mprod >>> FracBits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_wr_q <= '0;
      pj_wr_q <= '0;
      vpx_q <= '0;
      vpy_q <= '0;
      vpw_q <= 15'd640;
      vph_q <= 15'd480;
    end else begin
      if (load_en_i) begin
        if (load_sel_i) pj_wr_q[load_idx_i] <= 1'b1;
        else mv_wr_q[load_idx_i] <= 1'b1;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgVpX: vpx_q <= cfg_data_i;
          CfgVpY: vpy_q <= cfg_data_i;
          CfgVpW: vpw_q <= cfg_data_i[14:0];
          CfgVpH: vph_q <= cfg_data_i[14:0];
          default: ;
        endcase
      end
    end
  end

  // saturation helpers
  function automatic logic [32:0] sat66(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return {1'b1, 32'h7fffffff};
    if (v < -66'sd2147483648) return {1'b1, 32'h80000000};
    return {1'b0, v[31:0]};
  endfunction

  logic [32:0] row_sat;
  assign row_sat = sat66(acc_q);

  logic [QW:0] trial;
  assign trial = {rem_q[QW-1:0], quo_q[QW-1]} - {{(QW-32){1'b0}}, dvs_q};

  logic signed [QW:0] qs;
  logic signed [33:0] qmap;
  logic [32:0] qsat;
  always_comb begin
    qs = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
    if (qs > (QW+1)'(33'sd2147483647)) qsat = {1'b1, 32'h7fffffff};
    else if (qs < -(QW+1)'(33'sd2147483648)) qsat = {1'b1, 32'h80000000};
    else qsat = {1'b0, qs[31:0]};
    qmap = ($signed({qsat[31], qsat[31:0]}) + 34'(One)) >>> 1;
  end

  logic signed [49:0] vpsum;
  logic [32:0] vpsat;
  always_comb begin
    vpsum = 50'(prod_q) + (50'($signed(cmd_i.comp[0] ? vpy_q : vpx_q)) <<< FracBits);
    if (vpsum > 50'sd2147483647) vpsat = {1'b1, 32'h7fffffff};
    else if (vpsum < -50'sd2147483648) vpsat = {1'b1, 32'h80000000};
    else vpsat = {1'b0, vpsum[31:0]};
  end

  logic signed [31:0] clip_c;
  assign clip_c = vout_q[cmd_i.comp];

  always_ff @(posedge clk_i) begin
    if (load_en_i) begin
      if (load_sel_i) pj_q[load_idx_i] <= load_val_i;
      else mv_q[load_idx_i] <= load_val_i;
    end
    if (cmd_i.start) begin
      vin_q[0] <= obj_x_i;
      vin_q[1] <= obj_y_i;
      vin_q[2] <= obj_z_i;
      vin_q[3] <= One;
      acc_q <= '0;
      col_q <= '0;
      sat_q <= 1'b0;
    end
    if (cmd_i.mac) begin
      acc_q <= acc_q + 66'(pshift);
      col_q <= col_q + 2'd1;
    end
    if (cmd_i.row_end) begin
      vout_q[cmd_i.mac_sel[2:1]] <= row_sat[31:0];
      sat_q <= sat_q | row_sat[32];
      acc_q <= '0;
      if (cmd_i.mac_sel[2:1] == 2'd3 && !cmd_i.mac_sel[3]) begin
        vin_q[0] <= vout_q[0];
        vin_q[1] <= vout_q[1];
        vin_q[2] <= vout_q[2];
        vin_q[3] <= row_sat[31:0];
      end
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= QW'({clip_c[31] ? -{clip_c[31], clip_c} : {clip_c[31], clip_c}}) << FracBits;
      dvs_q <= vout_q[3][31] ? -{vout_q[3][31], vout_q[3]} : {vout_q[3][31], vout_q[3]};
      neg_q <= clip_c[31] ^ vout_q[3][31];
    end
    if (cmd_i.div_step) begin
      if (!trial[QW]) begin
        rem_q <= trial[QW-1:0];
        quo_q <= {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[QW-2:0], quo_q[QW-1]};
        quo_q <= {quo_q[QW-2:0], 1'b0};
      end
    end
    if (cmd_i.div_end) begin
      m_q[cmd_i.comp] <= qmap[31:0];
      sat_q <= sat_q | qsat[32];
    end
    if (cmd_i.vp_mul) begin
      prod_q <= m_q[cmd_i.comp] * $signed({1'b0, cmd_i.comp[0] ? vph_q : vpw_q});
    end
    if (cmd_i.vp_end) begin
      win_q[cmd_i.comp[0]] <= vpsat[31:0];
      sat_q <= sat_q | vpsat[32];
    end
    if (cmd_i.load_out) begin
      ok_q <= !sts_o.w_zero;
      osat_q <= sat_q;
      owx_q <= sts_o.w_zero ? '0 : win_q[0];
      owy_q <= sts_o.w_zero ? '0 : win_q[1];
      owz_q <= sts_o.w_zero ? '0 : m_q[2];
    end
  end

  assign sts_o.w_zero = (vout_q[3] == '0);
  assign ok_o = ok_q;
  assign sat_o = osat_q;
  assign wx_o = owx_q;
  assign wy_o = owy_q;
  assign wz_o = owz_q;

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the vertex projection unit: matrix loads and vertex
// projections are driven through valid / ready channels under several
// viewport settings and idling mixes, and every returned item is compared
// field by field with a typed value or a fixed-point model kept inside the bench
// ----------------------------------------------------------------------------
module tb;
  import vptw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  FracBits  = 16;
  localparam longint One    = longint'(1) << FracBits;
  localparam longint S32Max = 64'sd2147483647;
  localparam longint S32Min = -64'sd2147483648;
  localparam int  Drain     = 250;       // wait after the last result comes back
  localparam int  Limit     = 3000000;   // cycles before the run is abandoned
  localparam int  NumPhases = 8;
  localparam int  PerPhase  = 200;

  // one input item: load (cmd 0) or vertex (cmd 1)
  typedef struct packed {
    logic              cmd;
    logic              matrix_select;
    logic [3:0]        element_index;
    logic signed [31:0] element_value;
    logic signed [31:0] object_x;
    logic signed [31:0] object_y;
    logic signed [31:0] object_z;
  } vtx_item_t;

  // one result item
  typedef struct packed {
    logic              ok;
    logic              saturated;
    logic signed [31:0] window_x;
    logic signed [31:0] window_y;
    logic signed [31:0] window_z;
  } win_item_t;

  // expectation typed into the stimulus table, or left to the model
  typedef struct {
    bit        typed;
    win_item_t win;
  } typed_exp_t;

  typedef struct {
    vtx_item_t  item;
    bit         typed;
    win_item_t  win;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  vptw_stream_if #(.payload_t(vtx_item_t)) in_ch ();
  vptw_stream_if #(.payload_t(win_item_t)) out_ch ();

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  vertex_project_to_window_unit #(.FracBits(FracBits)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // model state: matrices column-major, viewport registers
  longint mv_mat[16];
  longint pj_mat[16];
  longint vp_x, vp_y, vp_w, vp_h;

  win_item_t  window_q[$];      // projections still to come back
  typed_exp_t table_exp_q[$];   // one entry per item offered, in order
  int errors = 0;
  int n_results = 0;
  int n_loads = 0;
  int n_wzero = 0;
  int n_sat = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cnt = 0;

  function automatic longint clamp32(longint v, inout bit f);
    if (v > S32Max) begin
      f = 1'b1;
      return S32Max;
    end
    if (v < S32Min) begin
      f = 1'b1;
      return S32Min;
    end
    return v;
  endfunction

  // matrix times vector, each product floored back to the fixed point
  function automatic void mat_times(input longint m[16], input longint v[4],
                                    output longint d[4], inout bit f);
    longint acc;
    for (int r = 0; r < 4; r++) begin
      acc = 0;
      for (int c = 0; c < 4; c++) acc += (m[c*4+r] * v[c]) >>> FracBits;
      d[r] = clamp32(acc, f);
    end
  endfunction

  // divide by clip w toward zero, then map -1..1 onto 0..1
  function automatic longint div_map(longint c, longint w, inout bit f);
    longint q;
    q = clamp32((c * One) / w, f);
    return (q + One) >>> 1;
  endfunction

  function automatic win_item_t project_vertex(vtx_item_t it);
    longint obj[4], eye[4], clp[4];
    longint mx, my;
    bit f;
    win_item_t r;
    f = 1'b0;
    r = '0;
    obj[0] = longint'(it.object_x);
    obj[1] = longint'(it.object_y);
    obj[2] = longint'(it.object_z);
    obj[3] = One;
    mat_times(mv_mat, obj, eye, f);
    mat_times(pj_mat, eye, clp, f);
    if (clp[3] != 0) begin
      r.ok = 1'b1;
      mx = div_map(clp[0], clp[3], f);
      my = div_map(clp[1], clp[3], f);
      r.window_z = 32'(div_map(clp[2], clp[3], f));
      r.window_x = 32'(clamp32(mx * vp_w + vp_x * One, f));
      r.window_y = 32'(clamp32(my * vp_h + vp_y * One, f));
    end
    r.saturated = f;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("error at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    errors++;
  endtask

  // input side: every accepted item updates the model or queues a result
  always @(posedge clk_i) begin
    typed_exp_t te;
    win_item_t got, want;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        te = table_exp_q.pop_front();
        if (in_ch.data.cmd == CmdLoad) begin
          n_loads++;
          if (in_ch.data.matrix_select)
            pj_mat[in_ch.data.element_index] = longint'(in_ch.data.element_value);
          else
            mv_mat[in_ch.data.element_index] = longint'(in_ch.data.element_value);
        end else begin
          want = te.typed ? te.win : project_vertex(in_ch.data);
          window_q.push_back(want);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (window_q.size() == 0) begin
          report_mismatch("unexpected result items", 1, 0);
        end else begin
          want = window_q.pop_front();
          n_results++;
          if (!want.ok) n_wzero++;
          if (want.saturated) n_sat++;
          if (got.ok !== want.ok) report_mismatch("ok", got.ok, want.ok);
          if (got.saturated !== want.saturated)
            report_mismatch("saturated", got.saturated, want.saturated);
          if (got.window_x !== want.window_x)
            report_mismatch("window_x", got.window_x, want.window_x);
          if (got.window_y !== want.window_y)
            report_mismatch("window_y", got.window_y, want.window_y);
          if (got.window_z !== want.window_z)
            report_mismatch("window_z", got.window_z, want.window_z);
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off while hold_cnt runs down
  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      out_ch.ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // called at a falling edge; leaves valid high after acceptance
  task automatic offer(vtx_item_t it, bit typed = 1'b0, win_item_t win = '0);
    typed_exp_t te;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    te.typed = typed;
    te.win = win;
    table_exp_q.push_back(te);
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic vtx_item_t mk_load(bit sel, int idx, longint v);
    vtx_item_t it;
    it = '0;
    it.cmd = CmdLoad;
    it.matrix_select = sel;
    it.element_index = 4'(idx);
    it.element_value = 32'(v);
    return it;
  endfunction

  function automatic vtx_item_t mk_vertex(longint x, longint y, longint z);
    vtx_item_t it;
    it = '0;
    it.cmd = CmdProject;
    it.object_x = 32'(x);
    it.object_y = 32'(y);
    it.object_z = 32'(z);
    return it;
  endfunction

  function automatic win_item_t mk_win(bit ok, longint x, longint y, longint z);
    win_item_t w;
    w.ok = ok;
    w.saturated = 1'b0;
    w.window_x = 32'(x);
    w.window_y = 32'(y);
    w.window_z = 32'(z);
    return w;
  endfunction

  // wait for every result, then let any trailing work finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (window_q.size() != 0) @(negedge clk_i);
    repeat (Drain) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CfgVpX: vp_x = longint'($signed(val));
      CfgVpY: vp_y = longint'($signed(val));
      CfgVpW: vp_w = longint'(val[14:0]);
      default: vp_h = longint'(val[14:0]);
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic longint rand_word();
    return longint'($signed(32'($urandom)));
  endfunction

  // small signed fixed-point value within +-2^bits
  function automatic longint rand_small(int bits);
    return longint'($urandom_range(0, (1 << (bits + 1)) - 1)) - (longint'(1) << bits);
  endfunction

  // a random matrix, diagonal entries sometimes near one, projection ones sometimes with a zero w row
  task automatic load_matrix(bit sel);
    bit zero_w;
    longint v;
    zero_w = sel && ($urandom_range(3) == 0);
    for (int i = 0; i < 16; i++) begin
      v = rand_small(FracBits + 2);
      if (i % 5 == 0 && $urandom_range(1)) v = One + rand_small(FracBits - 2);
      if (zero_w && (i % 4 == 3)) v = 0;
      offer(mk_load(sel, i, v));
    end
  endtask

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    int r;
    logic [15:0] cx, cy, cw, chh;

    for (int i = 0; i < 16; i++) begin
      mv_mat[i] = (i % 5 == 0) ? One : 0;
      pj_mat[i] = (i % 5 == 0) ? One : 0;
    end
    vp_x = 0;
    vp_y = 0;
    vp_w = 640;
    vp_h = 480;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table; typed rows: two after-reset identity cases and a zero clip w case
    row.typed = 1'b1;
    row.item = mk_vertex(One, One / 2, 0);
    row.win = mk_win(1'b1, 640 * One, 360 * One, One / 2);
    rows.push_back(row);
    row.item = mk_vertex(0, 0, 0);
    row.win = mk_win(1'b1, 320 * One, 240 * One, One / 2);
    rows.push_back(row);
    row.typed = 1'b0;
    row.item = mk_vertex(S32Max, S32Max, S32Max);
    rows.push_back(row);
    row.item = mk_vertex(S32Min, S32Min, S32Min);
    rows.push_back(row);
    row.item = mk_vertex(S32Max, S32Min, 0);
    rows.push_back(row);
    row.item = mk_load(1'b0, 0, S32Max);
    rows.push_back(row);
    row.item = mk_load(1'b0, 12, S32Min);
    rows.push_back(row);
    row.item = mk_vertex(S32Max, 1, -1);
    rows.push_back(row);
    row.item = mk_vertex(-One, One, S32Min);
    rows.push_back(row);
    // restore modelview, then zero clip w through the projection matrix
    row.item = mk_load(1'b0, 0, One);
    rows.push_back(row);
    row.item = mk_load(1'b0, 12, 0);
    rows.push_back(row);
    row.item = mk_load(1'b1, 15, 0);
    rows.push_back(row);
    row.typed = 1'b1;
    row.item = mk_vertex(One, 2 * One, 3 * One);
    row.win = mk_win(1'b0, 0, 0, 0);
    rows.push_back(row);
    row.typed = 1'b0;
    row.item = mk_load(1'b1, 15, One);
    rows.push_back(row);
    // tiny w makes the divide clamp
    row.item = mk_load(1'b1, 15, 1);
    rows.push_back(row);
    row.item = mk_vertex(S32Max, S32Min, One);
    rows.push_back(row);
    row.item = mk_load(1'b1, 15, -One);
    rows.push_back(row);
    row.item = mk_vertex(One / 3, -One / 7, One / 5);
    rows.push_back(row);
    row.item = mk_load(1'b1, 15, One);
    rows.push_back(row);

    foreach (rows[i]) offer(rows[i].item, rows[i].typed, rows[i].win);
    settle();

    for (int ph = 0; ph < NumPhases; ph++) begin
      // viewport: extremes in the first two phases, the default in the third, random after
      case (ph)
        0: begin cx = 16'h8000; cy = 16'h7fff; cw = 16'h7fff; chh = 16'h0000; end
        1: begin cx = 16'h7fff; cy = 16'h8000; cw = 16'h0000; chh = 16'h7fff; end
        2: begin cx = 16'h0000; cy = 16'h0000; cw = 16'd640;  chh = 16'd480;  end
        default: begin
          cx = 16'($urandom);
          cy = 16'($urandom);
          cw = 16'($urandom);
          chh = 16'($urandom);
        end
      endcase
      write_reg(CfgVpX, cx);
      write_reg(CfgVpY, cy);
      write_reg(CfgVpW, cw);
      write_reg(CfgVpH, chh);

      // idling mix: none, sender idle, receiver stalling, both
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      // long receiver hold-off so the unit fills and stalls its input
      if (ph == 0) hold_cnt = 1500;

      for (int n = 0; n < PerPhase; n++) begin
        r = $urandom_range(99);
        if (r < 6) begin
          load_matrix(1'($urandom));
          n += 15;
        end else if (r < 12) begin
          offer(mk_load(1'($urandom), $urandom_range(15), rand_word()));
        end else if (r < 14) begin
          // sender pause until every result is back
          in_ch.valid <= 1'b0;
          while (window_q.size() != 0) @(negedge clk_i);
          @(negedge clk_i);
        end else if (r < 30) begin
          offer(mk_vertex(rand_word(), rand_word(), rand_word()));
        end else begin
          offer(mk_vertex(rand_small(FracBits + 8), rand_small(FracBits + 8),
                          rand_small(FracBits + 8)));
        end
      end
      settle();
    end

    $display("covered %0d matrix loads and %0d projections over %0d viewport settings",
             n_loads, n_results, NumPhases + 1);
    $display("of those, %0d had zero clip w and %0d reported clamping", n_wzero, n_sat);
    if (errors == 0 && table_exp_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
